// ===== rtl/psm_pkg.sv =====
// Shared constants and types for the five-point Laplacian stencil block.
package psm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_W         = 10;
  localparam int CFG_W         = 11;
  localparam int DATA_W        = 32;
  localparam int AP_W          = 35;
  localparam int SUM_W         = 36;
  localparam int RES_DEPTH     = 4;
  localparam int RES_PTR_W     = 2;
  localparam int RES_CNT_W     = 3;
  localparam int CFG_RESET     = 64;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } psm_reg_t;

  typedef struct packed {
    logic signed [AP_W-1:0] ap;
    logic                   eoi;
    logic                   eog;
  } psm_result_t;

endpackage

// ===== rtl/poisson_stencil_matvec_top.sv =====
// A cell's result is queued when the input of the row above it is accepted.
// Throughput: one input per cycle while the result queue has room (in_ready high);
// each last-row input gives two results, and the single output port sends one at a time.
// Line stores are two single-port-write RAMs, read ahead of the written cell; they are not cleared.
// Reset (synchronous, active high) clears the counters and result queue and sets both
// grid size registers to 64. A register write restarts the grid at row 0, column 0.
module poisson_stencil_matvec_top
  import psm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] pressure_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [AP_W-1:0]   ap_value,
  output logic                     end_of_item,
  output logic                     end_of_grid
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;

  // Line stores: cur_mem holds the newest row, prev_mem the one before it.
  logic [DATA_W-1:0] cur_mem  [MAX_WIDTH];
  logic [DATA_W-1:0] prev_mem [MAX_WIDTH];
  logic signed [DATA_W-1:0] cur_rd;   // newest row at the next column
  logic signed [DATA_W-1:0] prev_rd;  // older row at this column
  logic signed [DATA_W-1:0] cur_c;    // newest row at this column
  logic signed [DATA_W-1:0] west;     // newest row at the column before

  psm_result_t res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr;
  logic [RES_PTR_W-1:0] rptr;
  logic [RES_CNT_W-1:0] count;

  logic [CMPW-1:0]  gw_ext;
  logic [CMPW-1:0]  w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [AW-1:0]    w_last;
  logic [AW-1:0]    w_east;
  logic [ROW_W-1:0] h_last;
  logic [AW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;
  logic [AW-1:0]    prev_raddr;
  logic [AW-1:0]    cur_raddr;
  logic             accept;
  logic             pop;
  logic             push_a;
  logic             push_b;
  logic [RES_CNT_W-1:0] push_n;

  logic signed [SUM_W-1:0] pp;
  logic signed [SUM_W-1:0] pe;
  logic signed [SUM_W-1:0] pw;
  logic signed [SUM_W-1:0] pn;
  logic signed [SUM_W-1:0] ps;
  logic signed [SUM_W-1:0] sum;
  logic signed [AP_W-1:0]  ap_sat;
  logic                    interior;
  psm_result_t             res_a;
  psm_result_t             res_b;

  // Effective grid size, clamped to the supported range.
  always_comb begin
    gw_ext = CMPW'(grid_width);
    if (gw_ext < CMPW'(3)) begin
      w_eff = CMPW'(3);
    end else if (gw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = gw_ext;
    end
    if (grid_height < CFG_W'(3)) begin
      h_eff = CFG_W'(3);
    end else if (grid_height > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
    w_last = AW'(w_eff - CMPW'(1));
    w_east = AW'(w_eff - CMPW'(2));
    h_last = ROW_W'(h_eff - CFG_W'(1));
  end

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    if (col == w_last) begin
      col_next = '0;
      row_next = (row == h_last) ? '0 : row + ROW_W'(1);
    end else begin
      col_next = col + AW'(1);
      row_next = row;
    end
    prev_raddr = col_next;
    cur_raddr  = col_next + AW'(1);
  end

  // Stencil for the cell one row below the incoming one. Ghost columns copy the
  // neighbor (Neumann); ghost rows take its negation (Dirichlet zero).
  always_comb begin
    pp = SUM_W'(cur_c);
    pe = (col == w_east) ? pp : SUM_W'(cur_rd);
    pw = (col == AW'(1)) ? pp : SUM_W'(west);
    ps = (row == ROW_W'(2)) ? -pp : SUM_W'(prev_rd);
    pn = (row == h_last) ? -pp : SUM_W'(pressure_value);
    sum = pe + pw + pn + ps - (pp <<< 2);
    if (sum[SUM_W-1] != sum[AP_W-1]) begin
      ap_sat = sum[SUM_W-1] ? {1'b1, {(AP_W-1){1'b0}}} : {1'b0, {(AP_W-1){1'b1}}};
    end else begin
      ap_sat = sum[AP_W-1:0];
    end
    interior = (row >= ROW_W'(2)) && (col != '0) && (col != w_last);

    res_a.ap  = interior ? ap_sat : '0;
    res_a.eoi = (row != h_last);
    res_a.eog = 1'b0;
    res_b.ap  = '0;
    res_b.eoi = 1'b1;
    res_b.eog = (col == w_last);

    push_a = accept && (row != '0);
    push_b = accept && (row == h_last);
    push_n = RES_CNT_W'(push_a) + RES_CNT_W'(push_b);
  end

  // Configuration registers and grid position.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(CFG_RESET);
      grid_height <= CFG_W'(CFG_RESET);
      col         <= '0;
      row         <= '0;
    end else if (cfg_write) begin
      unique case (psm_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default:         grid_width  <= grid_width;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Read-modify-write of the line stores. Reads fetch the next cells ahead of
  // time, so they never hit the entry written in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mem[col]  <= pressure_value;
      prev_mem[col] <= cur_c;
      cur_rd        <= cur_mem[cur_raddr];
      prev_rd       <= prev_mem[prev_raddr];
      cur_c         <= cur_rd;
      west          <= cur_c;
    end
  end

  // Result queue: up to two results per transaction in, one out.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + RES_PTR_W'(push_n);
      rptr  <= rptr + RES_PTR_W'(pop);
      count <= count + push_n - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      res_q[wptr] <= res_a;
    end
    if (push_b) begin
      res_q[wptr + RES_PTR_W'(push_a)] <= res_b;
    end
  end

  assign out_valid   = (count != '0);
  assign ap_value    = res_q[rptr].ap;
  assign end_of_item = res_q[rptr].eoi;
  assign end_of_grid = res_q[rptr].eog;

endmodule
